@@ rtl/lrc_timestamp_tag_parser_assert.svh @@
// assertion macros for the lyric time tag parser
`ifndef LRC_TIMESTAMP_TAG_PARSER_ASSERT_SVH
`define LRC_TIMESTAMP_TAG_PARSER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define LTTP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LTTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lrc_tsp_pkg.sv @@
// shared constants and types of the lyric time tag parser
`timescale 1ns / 1ps
package lrc_tsp_pkg;

    localparam int CHAR_W   = 16;
    localparam int OFFSET_W = 23;
    localparam int TIME_W   = 26;
    localparam int EV_W     = 2;
    localparam int MIN_W    = 10;
    localparam int SEC_W    = 7;
    localparam int FRAC_W   = 10;

    localparam logic [CHAR_W-1:0] CH_NL    = 16'h000A;
    localparam logic [CHAR_W-1:0] CH_OPEN  = 16'h005B;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 16'h005D;
    localparam logic [CHAR_W-1:0] CH_COLON = 16'h003A;
    localparam logic [CHAR_W-1:0] CH_DOT   = 16'h002E;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 16'h0030;
    localparam logic [CHAR_W-1:0] CH_NINE  = 16'h0039;

    localparam logic [EV_W-1:0] EV_PLAIN  = 2'd0;
    localparam logic [EV_W-1:0] EV_TIME   = 2'd1;
    localparam logic [EV_W-1:0] EV_REJECT = 2'd2;
    localparam logic [EV_W-1:0] EV_LINE   = 2'd3;

    localparam logic [1:0] PH_MIN  = 2'd0;
    localparam logic [1:0] PH_SEC  = 2'd1;
    localparam logic [1:0] PH_FRAC = 2'd2;

    localparam logic [TIME_W-1:0] TIME_MAX = 26'd59999999;

    // one parsed beat handed from the parser stage to the time stage
    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [MIN_W-1:0]  minutes;
        logic [SEC_W-1:0]  seconds;
        logic [FRAC_W-1:0] frac_ms;
    } t_tag_beat;

endpackage

@@ rtl/lrc_tsp_parser.sv @@
// tag recognizer: per-character state update and the parsed-beat register
`timescale 1ns / 1ps
module lrc_tsp_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [lrc_tsp_pkg::CHAR_W-1:0] i_char_code,
    output logic                          o_valid,
    input  logic                          i_ready,
    output lrc_tsp_pkg::t_tag_beat        o_beat
);
    import lrc_tsp_pkg::*;

    logic              r_in_tag, n_in_tag;
    logic [1:0]        r_phase, n_phase;
    logic [MIN_W-1:0]  r_min_val, n_min_val;
    logic [2:0]        r_min_cnt, n_min_cnt;
    logic [SEC_W-1:0]  r_sec_val, n_sec_val;
    logic [1:0]        r_sec_cnt, n_sec_cnt;
    logic [FRAC_W-1:0] r_frac_val, n_frac_val;
    logic [2:0]        r_frac_cnt, n_frac_cnt;
    logic              r_invalid, n_invalid;

    logic              r_valid;
    t_tag_beat         r_beat, n_beat;

    logic              accept;
    logic              is_digit;
    logic [3:0]        digit;
    logic              close_ok;
    logic [FRAC_W-1:0] frac_ms;

    assign o_ready  = !r_valid || i_ready;
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_beat   = r_beat;

    assign is_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
    assign digit    = i_char_code[3:0];

    always_comb begin
        close_ok = !r_invalid && (r_sec_cnt == 2'd2) && (r_min_cnt != 3'd0) &&
                   ((r_phase == PH_SEC) || ((r_phase == PH_FRAC) && (r_frac_cnt != 3'd0)));
        case (r_frac_cnt)
            3'd1:    frac_ms = FRAC_W'(r_frac_val * 7'd100);
            3'd2:    frac_ms = FRAC_W'(r_frac_val * 4'd10);
            3'd3:    frac_ms = r_frac_val;
            default: frac_ms = '0;
        endcase
        if (r_phase != PH_FRAC) begin
            frac_ms = '0;
        end
    end

    always_comb begin
        n_in_tag   = r_in_tag;
        n_phase    = r_phase;
        n_min_val  = r_min_val;
        n_min_cnt  = r_min_cnt;
        n_sec_val  = r_sec_val;
        n_sec_cnt  = r_sec_cnt;
        n_frac_val = r_frac_val;
        n_frac_cnt = r_frac_cnt;
        n_invalid  = r_invalid;

        n_beat.ev      = EV_PLAIN;
        n_beat.minutes = r_min_val;
        n_beat.seconds = r_sec_val;
        n_beat.frac_ms = frac_ms;

        if (i_char_code == CH_NL || i_char_code == CH_OPEN ||
            (r_in_tag && i_char_code == CH_CLOSE)) begin
            // every one of these leaves a clean tag state behind
            n_in_tag   = (i_char_code == CH_OPEN);
            n_phase    = PH_MIN;
            n_min_val  = '0;
            n_min_cnt  = '0;
            n_sec_val  = '0;
            n_sec_cnt  = '0;
            n_frac_val = '0;
            n_frac_cnt = '0;
            n_invalid  = 1'b0;
            if (i_char_code == CH_NL) begin
                n_beat.ev = EV_LINE;
            end else if (i_char_code == CH_CLOSE && close_ok) begin
                n_beat.ev = (r_sec_val >= SEC_W'(60)) ? EV_REJECT : EV_TIME;
            end
        end else if (r_in_tag && !r_invalid) begin
            case (r_phase)
                PH_MIN: begin
                    if (is_digit && r_min_cnt < 3'd3) begin
                        n_min_val = MIN_W'(r_min_val * 4'd10) + MIN_W'(digit);
                        n_min_cnt = r_min_cnt + 3'd1;
                    end else if (i_char_code == CH_COLON && r_min_cnt != 3'd0) begin
                        n_phase = PH_SEC;
                    end else begin
                        n_invalid = 1'b1;
                    end
                end
                PH_SEC: begin
                    if (is_digit && r_sec_cnt < 2'd2) begin
                        n_sec_val = SEC_W'(r_sec_val * 4'd10) + SEC_W'(digit);
                        n_sec_cnt = r_sec_cnt + 2'd1;
                    end else if ((i_char_code == CH_DOT || i_char_code == CH_COLON) &&
                                 r_sec_cnt == 2'd2) begin
                        n_phase = PH_FRAC;
                    end else begin
                        n_invalid = 1'b1;
                    end
                end
                PH_FRAC: begin
                    if (is_digit && r_frac_cnt < 3'd3) begin
                        n_frac_val = FRAC_W'(r_frac_val * 4'd10) + FRAC_W'(digit);
                        n_frac_cnt = r_frac_cnt + 3'd1;
                    end else begin
                        n_invalid = 1'b1;
                    end
                end
                default: n_invalid = 1'b1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_tag   <= 1'b0;
            r_phase    <= PH_MIN;
            r_min_val  <= '0;
            r_min_cnt  <= '0;
            r_sec_val  <= '0;
            r_sec_cnt  <= '0;
            r_frac_val <= '0;
            r_frac_cnt <= '0;
            r_invalid  <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_in_tag   <= n_in_tag;
                r_phase    <= n_phase;
                r_min_val  <= n_min_val;
                r_min_cnt  <= n_min_cnt;
                r_sec_val  <= n_sec_val;
                r_sec_cnt  <= n_sec_cnt;
                r_frac_val <= n_frac_val;
                r_frac_cnt <= n_frac_cnt;
                r_invalid  <= n_invalid;
                r_valid    <= 1'b1;
            end else if (i_ready) begin
                r_valid    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beat <= n_beat;
        end
    end

endmodule

@@ rtl/lrc_tsp_time.sv @@
// time stage: offset register, millisecond sum, clamp and result register
`timescale 1ns / 1ps
module lrc_tsp_time (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_offset_ms_we,
    input  logic [lrc_tsp_pkg::OFFSET_W-1:0] i_offset_ms,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  lrc_tsp_pkg::t_tag_beat           i_beat,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lrc_tsp_pkg::EV_W-1:0]     o_event_res,
    output logic [lrc_tsp_pkg::TIME_W-1:0]   o_time_ms
);
    import lrc_tsp_pkg::*;

    localparam int T_W = TIME_W + 2;

    logic [OFFSET_W-1:0] r_offset;
    logic                r_valid;
    logic [EV_W-1:0]     r_event;
    logic [TIME_W-1:0]   r_time, n_time;

    logic                accept;
    logic [TIME_W-1:0]   min_ms;
    logic [TIME_W-1:0]   sum_ms;
    logic signed [T_W-1:0] t_ms;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        min_ms = TIME_W'(i_beat.minutes) * TIME_W'(60000);
        sum_ms = min_ms + TIME_W'(TIME_W'(i_beat.seconds) * TIME_W'(1000))
                 + TIME_W'(i_beat.frac_ms);
        t_ms   = $signed({2'b00, sum_ms}) - $signed(T_W'($signed(r_offset)));
        if (i_beat.ev != EV_TIME || t_ms < 0) begin
            n_time = '0;
        end else if (t_ms > $signed({2'b00, TIME_MAX})) begin
            n_time = TIME_MAX;
        end else begin
            n_time = t_ms[TIME_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_valid  <= 1'b0;
        end else begin
            if (i_offset_ms_we) begin
                r_offset <= i_offset_ms;
            end
            if (accept) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_event <= i_beat.ev;
            r_time  <= n_time;
        end
    end

    assign o_valid     = r_valid;
    assign o_event_res = r_event;
    assign o_time_ms   = r_time;

endmodule

@@ rtl/lrc_timestamp_tag_parser.sv @@
// top level of the lyric time tag parser
// Usage:
//   input channel i_valid / o_ready carries one UTF-16 code unit per beat on
//   i_char_code; output channel o_valid / i_ready carries one result per
//   input beat: o_event_res (plain, timestamp, rejected tag, line end) and
//   o_time_ms, which is nonzero only on a timestamp event.
//   i_offset_ms_we writes the signed offset i_offset_ms; write it only while
//   no beat is in flight.
// Pipeline: the tag recogniser register feeds the register that holds the
//   millisecond sum and clamp result.
// Throughput: one beat per cycle, sustained while i_ready stays high.
// Stall: each of the two stages holds its beat while the one behind it is
//   full, so with i_ready low two beats are buffered before o_ready drops;
//   nothing is lost or repeated.
// Reset: synchronous, active low; clears the tag state, the offset to zero
//   and both stage valids.
`timescale 1ns / 1ps
`include "lrc_timestamp_tag_parser_assert.svh"
module lrc_timestamp_tag_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [lrc_tsp_pkg::CHAR_W-1:0]   i_char_code,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lrc_tsp_pkg::EV_W-1:0]     o_event_res,
    output logic [lrc_tsp_pkg::TIME_W-1:0]   o_time_ms,
    input  logic                             i_offset_ms_we,
    input  logic [lrc_tsp_pkg::OFFSET_W-1:0] i_offset_ms
);
    import lrc_tsp_pkg::*;

    logic      s1_valid;
    logic      s2_ready;
    t_tag_beat s1_beat;

    logic      plain_out;
    logic      nl_in;
    logic      s1_line;

    lrc_tsp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_char_code (i_char_code),
        .o_valid     (s1_valid),
        .i_ready     (s2_ready),
        .o_beat      (s1_beat)
    );

    lrc_tsp_time u_time (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_offset_ms_we (i_offset_ms_we),
        .i_offset_ms    (i_offset_ms),
        .i_valid        (s1_valid),
        .o_ready        (s2_ready),
        .i_beat         (s1_beat),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_res    (o_event_res),
        .o_time_ms      (o_time_ms)
    );

    assign plain_out = o_valid && (o_event_res != EV_TIME);
    assign nl_in     = i_valid && o_ready && (i_char_code == CH_NL);
    assign s1_line   = s1_valid && (s1_beat.ev == EV_LINE);

    `LTTP_ASSERT_IMP(a_time_only_on_stamp, plain_out, o_time_ms == '0, "time set off a timestamp")
    `LTTP_ASSERT_IMP(a_time_in_range, o_valid, o_time_ms <= TIME_MAX, "time above range")
    `LTTP_ASSERT_NEXT(a_newline_line_end, nl_in, s1_line, "newline gave no line end")
    `LTTP_ASSERT_IMP(a_stall_only_when_full, !o_ready, s1_valid && o_valid, "stalled while not full")

endmodule

@@ tb/lrc_timestamp_tag_parser_tb.sv @@
// testbench of the lyric time tag parser: random lyric lines checked against a tag scoreboard
`timescale 1ns / 1ps
module lrc_timestamp_tag_parser_tb;
    import lrc_tsp_pkg::*;

    localparam int RX_FREE = 0;
    localparam int RX_COIN = 1;
    localparam int RX_SLOW = 2;

    localparam int BRK_COUNT    = 0;
    localparam int BRK_INSERT   = 1;
    localparam int BRK_DROP     = 2;
    localparam int BRK_UNCLOSED = 3;

    typedef struct packed {
        logic [EV_W-1:0]   ev;
        logic [TIME_W-1:0] tm;
    } t_tag_event;

    class t_tag_event_board;
        bit                         in_tag;
        logic [1:0]                 phase;
        int unsigned                min_val, min_cnt, sec_val, sec_cnt, frac_val, frac_cnt;
        bit                         bad;
        logic signed [OFFSET_W-1:0] offset_ms;
        t_tag_event                 pending_events[$];
        int                         errors, n_checked, n_time, n_reject, n_line;

        function new();
            offset_ms = '0;
            clear_tag();
        endfunction

        function void clear_tag();
            in_tag   = 1'b0;
            phase    = PH_MIN;
            min_val  = 0;
            min_cnt  = 0;
            sec_val  = 0;
            sec_cnt  = 0;
            frac_val = 0;
            frac_cnt = 0;
            bad      = 1'b0;
        endfunction

        function t_tag_event close_tag();
            bit          ok;
            longint      t;
            int unsigned frac;
            t_tag_event  e;
            e.ev = EV_PLAIN;
            e.tm = '0;
            frac = 0;
            ok = !bad && min_cnt >= 1 && min_cnt <= 3 && sec_cnt == 2;
            if (phase == PH_FRAC) begin
                if (frac_cnt < 1 || frac_cnt > 3)
                    ok = 1'b0;
                else if (frac_cnt == 1)
                    frac = frac_val * 100;
                else if (frac_cnt == 2)
                    frac = frac_val * 10;
                else
                    frac = frac_val;
            end else if (phase != PH_SEC) begin
                ok = 1'b0;
            end
            if (!ok)
                return e;
            if (sec_val >= 60) begin
                e.ev = EV_REJECT;
                return e;
            end
            t = longint'(min_val) * 60000 + longint'(sec_val) * 1000 + longint'(frac)
                - longint'(offset_ms);
            if (t < 0)
                t = 0;
            if (t > longint'(TIME_MAX))
                t = longint'(TIME_MAX);
            e.ev = EV_TIME;
            e.tm = t[TIME_W-1:0];
            return e;
        endfunction

        // one accepted input beat: advance the tag state and queue its result
        function void note_char(logic [CHAR_W-1:0] c);
            bit          digit;
            int unsigned d;
            t_tag_event  e;
            digit = (c >= CH_ZERO) && (c <= CH_NINE);
            d     = digit ? int'(c - CH_ZERO) : 0;
            e.ev  = EV_PLAIN;
            e.tm  = '0;
            if (c == CH_NL) begin
                clear_tag();
                e.ev = EV_LINE;
            end else if (c == CH_OPEN) begin
                clear_tag();
                in_tag = 1'b1;
            end else if (in_tag) begin
                if (c == CH_CLOSE) begin
                    e = close_tag();
                    clear_tag();
                end else if (!bad) begin
                    case (phase)
                        PH_MIN: begin
                            if (digit && min_cnt < 3) begin
                                min_val = min_val * 10 + d;
                                min_cnt++;
                            end else if (c == CH_COLON && min_cnt != 0) begin
                                phase = PH_SEC;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        PH_SEC: begin
                            if (digit && sec_cnt < 2) begin
                                sec_val = sec_val * 10 + d;
                                sec_cnt++;
                            end else if ((c == CH_DOT || c == CH_COLON) && sec_cnt == 2) begin
                                phase = PH_FRAC;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        PH_FRAC: begin
                            if (digit && frac_cnt < 3) begin
                                frac_val = frac_val * 10 + d;
                                frac_cnt++;
                            end else begin
                                bad = 1'b1;
                            end
                        end
                        default: bad = 1'b1;
                    endcase
                end
            end
            pending_events = {pending_events, e};
        endfunction

        function void check_event(logic [EV_W-1:0] ev, logic [TIME_W-1:0] tm);
            t_tag_event e;
            if (pending_events.size() == 0) begin
                $error("result beat with nothing expected: event_res %0d time_ms %0d", ev, tm);
                errors++;
                return;
            end
            e = pending_events[0];
            pending_events.delete(0);
            n_checked++;
            if (ev !== e.ev) begin
                $error("event_res: expected %0d, got %0d", e.ev, ev);
                errors++;
            end
            if (tm !== e.tm) begin
                $error("time_ms: expected %0d, got %0d", e.tm, tm);
                errors++;
            end
            case (e.ev)
                EV_TIME:   n_time++;
                EV_REJECT: n_reject++;
                EV_LINE:   n_line++;
                default:   ;
            endcase
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n        = 1'b0;
    logic                i_valid        = 1'b0;
    logic                o_ready;
    logic [CHAR_W-1:0]   i_char_code    = '0;
    logic                o_valid;
    logic                i_ready        = 1'b0;
    logic [EV_W-1:0]     o_event_res;
    logic [TIME_W-1:0]   o_time_ms;
    logic                i_offset_ms_we = 1'b0;
    logic [OFFSET_W-1:0] i_offset_ms    = '0;

    t_tag_event_board board;
    int burst_left = 0;
    int chars_sent = 0;
    int n_settings = 1;
    int ready_mode = RX_FREE;
    int mode_left  = 0;

    lrc_timestamp_tag_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_char_code    (i_char_code),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_res    (o_event_res),
        .o_time_ms      (o_time_ms),
        .i_offset_ms_we (i_offset_ms_we),
        .i_offset_ms    (i_offset_ms)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver: stall pattern switches between free running, coin toss and mostly stalled
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_event(o_event_res, o_time_ms);
        if (mode_left == 0) begin
            ready_mode <= $urandom_range(RX_FREE, RX_SLOW);
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            RX_FREE: i_ready <= 1'b1;
            RX_COIN: i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // sender works in bursts with idle gaps in between
    task automatic drive_char(input logic [CHAR_W-1:0] c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.note_char(c);
        chars_sent++;
        burst_left--;
    endtask

    task automatic send_string(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            drive_char({8'h00, s[i]});
    endtask

    task automatic wait_idle();
        i_valid    <= 1'b0;
        burst_left = 0;
        while (board.pending_events.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_offset(input int v);
        @(posedge i_clk);
        i_offset_ms_we <= 1'b1;
        i_offset_ms    <= v[OFFSET_W-1:0];
        @(posedge i_clk);
        i_offset_ms_we <= 1'b0;
        board.offset_ms = v[OFFSET_W-1:0];
        n_settings++;
    endtask

    function automatic logic [CHAR_W-1:0] rand_digit();
        return CH_ZERO + CHAR_W'($urandom_range(0, 9));
    endfunction

    function automatic logic [CHAR_W-1:0] odd_char();
        case ($urandom_range(0, 6))
            0:       return rand_digit();
            1:       return CH_COLON;
            2:       return CH_DOT;
            3:       return CH_OPEN;
            4:       return CH_CLOSE;
            5:       return CH_NL;
            default: return CHAR_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic send_text(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 4) == 0)
                drive_char(CHAR_W'($urandom_range(0, 16'hFFFF)));
            else
                drive_char(CHAR_W'($urandom_range(16'h20, 16'h7E)));
        end
    endtask

    task automatic send_tag(input bit broken);
        logic [CHAR_W-1:0] body[$];
        logic [CHAR_W-1:0] delim;
        int nmin, nsec, nfrac, i, kind;
        bit has_delim;
        nmin      = $urandom_range(1, 3);
        nsec      = 2;
        nfrac     = $urandom_range(0, 3);
        has_delim = (nfrac != 0);
        delim     = $urandom_range(0, 1) ? CH_DOT : CH_COLON;
        kind      = $urandom_range(BRK_COUNT, BRK_UNCLOSED);
        if (broken && kind == BRK_COUNT) begin
            case ($urandom_range(0, 4))
                0: nmin = 0;
                1: nmin = 4;
                2: nsec = $urandom_range(0, 1);
                3: nsec = 3;
                default: begin
                    has_delim = 1'b1;
                    nfrac     = $urandom_range(0, 1) ? 0 : 4;
                end
            endcase
        end
        body = {body, CH_OPEN};
        for (i = 0; i < nmin; i++)
            body = {body, rand_digit()};
        body = {body, CH_COLON};
        for (i = 0; i < nsec; i++) begin
            // tens of seconds sometimes 6..9 so that rejected tags show up
            if (i == 0)
                body = {body, CH_ZERO + CHAR_W'(($urandom_range(0, 4) == 0) ?
                               $urandom_range(6, 9) : $urandom_range(0, 5))};
            else
                body = {body, rand_digit()};
        end
        if (has_delim) begin
            body = {body, delim};
            for (i = 0; i < nfrac; i++)
                body = {body, rand_digit()};
        end
        body = {body, CH_CLOSE};
        if (broken) begin
            case (kind)
                BRK_INSERT:   body.insert($urandom_range(1, body.size() - 1), odd_char());
                BRK_DROP:     body.delete($urandom_range(1, body.size() - 2));
                BRK_UNCLOSED: body.delete(body.size() - 1);
                default:      ;
            endcase
        end
        for (i = 0; i < body.size(); i++)
            drive_char(body[i]);
    endtask

    task automatic send_line();
        int n_tags, i;
        n_tags = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3);
        for (i = 0; i < n_tags; i++)
            send_tag($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0)
            send_text($urandom_range(0, 12));
        else
            send_text($urandom_range(0, 6));
        if ($urandom_range(0, 5) != 0)
            drive_char(CH_NL);
    endtask

    task automatic run_lines(input int n);
        int target;
        target = chars_sent + n;
        while (chars_sent < target)
            send_line();
        wait_idle();
    endtask

    initial begin
        board = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset offset: zero time, rejected seconds, stray bracket, line end, code unit extremes
        send_string("[0:00][1:60]]\n");
        drive_char(16'hFFFF);
        drive_char(16'h0000);
        run_lines(300);

        // large negative offset: largest tag saturates
        set_offset(-3600000);
        send_string("[999:59.999]");
        run_lines(300);

        // large positive offset: small tags clamp at zero
        set_offset(3600000);
        run_lines(300);
        set_offset(int'($urandom_range(0, 7200000)) - 3600000);
        run_lines(300);
        set_offset(0);
        run_lines(300);
        set_offset(int'($urandom_range(0, 3000)) - 1500);
        run_lines(300);

        wait_idle();
        repeat (4) @(posedge i_clk);
        $display("checked %0d result beats over %0d offset settings", board.n_checked,
                 n_settings);
        $display("seen %0d timestamps, %0d rejected tags, %0d line ends", board.n_time,
                 board.n_reject, board.n_line);
        if (board.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
